[hdl/fraction_add_reduce_unit_defines.svh]
// Assertion macros for the fraction add-and-reduce unit
`ifndef FRACTION_ADD_REDUCE_UNIT_DEFINES_SVH
`define FRACTION_ADD_REDUCE_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define FRAU_ASSERT_NOW(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define FRAU_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`else

`define FRAU_ASSERT_NOW(name, clk, rstn, pre, post, msg)
`define FRAU_ASSERT_NEXT(name, clk, rstn, pre, post, msg)

`endif

`endif

[hdl/frau_pkg.sv]
// Shared constants and types for the fraction add-and-reduce unit
package frau_pkg;

  localparam int VALUE_BITS_DEF = 16;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_GCD   = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_DIVN  = 7'b0010000,
    S_DIVD  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

[hdl/frau_sub.sv]
// Shared subtractor with borrow out, used by the gcd steps and the divider
module frau_sub #(
  parameter int WIDTH = 2 * frau_pkg::VALUE_BITS_DEF + 2
) (
  input  logic [WIDTH-1:0] lhs,
  input  logic [WIDTH-1:0] rhs,
  output logic [WIDTH-1:0] diff,
  output logic             borrow
);

  assign {borrow, diff} = {1'b0, lhs} - {1'b0, rhs};

endmodule

[hdl/fraction_add_reduce_unit.sv]
// Top level: adds two fractions and returns the sum in lowest terms
//
// An item with a zero denominator gives the result 0/0, and one whose sum is zero gives
// 0/1. Otherwise the unit runs a multiply phase on one shared multiplier, a binary
// gcd of subtract-or-shift steps, one shift per common factor of two to scale the gcd
// back, and two restoring divisions of 2*VALUE_BITS+1 quotient bits each; one
// subtractor serves gcd and divider. in_ready is high only between items; a finished
// result sits in the output register while the next item runs.
`include "fraction_add_reduce_unit_defines.svh"

module fraction_add_reduce_unit #(
  parameter int VALUE_BITS = frau_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VALUE_BITS-1:0]   in_first_numerator,
  input  logic [VALUE_BITS-1:0]   in_first_denominator,
  input  logic [VALUE_BITS-1:0]   in_second_numerator,
  input  logic [VALUE_BITS-1:0]   in_second_denominator,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*VALUE_BITS:0]   out_sum_numerator,
  output logic [2*VALUE_BITS-1:0] out_sum_denominator
);

  localparam int W  = VALUE_BITS;
  localparam int NB = 2 * W + 1;
  localparam int DB = 2 * W;
  localparam int KW = $clog2(NB + 1);
  localparam int CW = $clog2(NB);

  frau_pkg::state_t state_r, state_nxt;

  logic [W-1:0]  n1_r, n1_nxt, d1_r, d1_nxt, n2_r, n2_nxt, d2_r, d2_nxt;
  logic [DB-1:0] prod_r, prod_nxt;
  logic [NB-1:0] top_r, top_nxt;
  logic [DB-1:0] bottom_r, bottom_nxt;
  logic [NB-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [1:0]    mul_cnt_r, mul_cnt_nxt;
  logic [CW-1:0] div_cnt_r, div_cnt_nxt;
  logic [NB-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [NB-1:0] out_num_r, out_num_nxt;
  logic [DB-1:0] out_den_r, out_den_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [W-1:0]  mul_a, mul_b;
  logic [DB-1:0] mul_p;
  logic [NB:0]   sub_lhs, sub_rhs, sub_diff;
  logic          sub_borrow;
  logic          dividing;
  logic [NB-1:0] rem_step, quo_step;

  // shared multiplier, operands picked by step
  always_comb begin
    unique case (mul_cnt_r)
      2'd0: begin
        mul_a = n1_r;
        mul_b = d2_r;
      end
      2'd1: begin
        mul_a = n2_r;
        mul_b = d1_r;
      end
      default: begin
        mul_a = d1_r;
        mul_b = d2_r;
      end
    endcase
  end

  assign mul_p = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  assign dividing = (state_r == frau_pkg::S_DIVN) || (state_r == frau_pkg::S_DIVD);
  assign sub_lhs  = dividing ? {rem_r, quo_r[NB-1]} : {1'b0, a_r};
  assign sub_rhs  = dividing ? {1'b0, a_r} : {1'b0, b_r};

  frau_sub #(
    .WIDTH (NB + 1)
  ) u_sub (
    .lhs    (sub_lhs),
    .rhs    (sub_rhs),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // one restoring divider step
  assign rem_step = sub_borrow ? sub_lhs[NB-1:0] : sub_diff[NB-1:0];
  assign quo_step = {quo_r[NB-2:0], ~sub_borrow};

  always_comb begin
    state_nxt     = state_r;
    n1_nxt        = n1_r;
    d1_nxt        = d1_r;
    n2_nxt        = n2_r;
    d2_nxt        = d2_r;
    prod_nxt      = prod_r;
    top_nxt       = top_r;
    bottom_nxt    = bottom_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    mul_cnt_nxt   = mul_cnt_r;
    div_cnt_nxt   = div_cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      frau_pkg::S_IDLE: begin
        if (in_valid) begin
          n1_nxt      = in_first_numerator;
          d1_nxt      = in_first_denominator;
          n2_nxt      = in_second_numerator;
          d2_nxt      = in_second_denominator;
          mul_cnt_nxt = 2'd0;
          if (in_first_denominator == '0 || in_second_denominator == '0) begin
            top_nxt    = '0;
            bottom_nxt = '0;
            state_nxt  = frau_pkg::S_DONE;
          end else begin
            state_nxt = frau_pkg::S_MUL;
          end
        end
      end
      frau_pkg::S_MUL: begin
        mul_cnt_nxt = mul_cnt_r + 2'd1;
        unique case (mul_cnt_r)
          2'd0: prod_nxt = mul_p;
          2'd1: begin
            top_nxt  = {1'b0, prod_r};
            prod_nxt = mul_p;
          end
          2'd2: begin
            top_nxt  = top_r + {1'b0, prod_r};
            prod_nxt = mul_p;
          end
          default: begin
            bottom_nxt = prod_r;
            k_nxt      = '0;
            if (top_r == '0) begin
              bottom_nxt = DB'(1);
              state_nxt  = frau_pkg::S_DONE;
            end else begin
              a_nxt     = top_r;
              b_nxt     = {1'b0, prod_r};
              state_nxt = frau_pkg::S_GCD;
            end
          end
        endcase
      end
      frau_pkg::S_GCD: begin
        priority if (!sub_borrow && sub_diff == '0) begin
          state_nxt = frau_pkg::S_SCALE;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + KW'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (sub_borrow) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = {1'b0, sub_diff[NB-1:1]};
        end
      end
      frau_pkg::S_SCALE: begin
        if (k_r == '0) begin
          quo_nxt     = top_r;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = frau_pkg::S_DIVN;
        end else begin
          a_nxt = a_r << 1;
          k_nxt = k_r - KW'(1);
        end
      end
      frau_pkg::S_DIVN: begin
        rem_nxt     = rem_step;
        quo_nxt     = quo_step;
        div_cnt_nxt = div_cnt_r + CW'(1);
        if (div_cnt_r == CW'(NB - 1)) begin
          top_nxt     = quo_step;
          quo_nxt     = {1'b0, bottom_r};
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = frau_pkg::S_DIVD;
        end
      end
      frau_pkg::S_DIVD: begin
        rem_nxt     = rem_step;
        quo_nxt     = quo_step;
        div_cnt_nxt = div_cnt_r + CW'(1);
        if (div_cnt_r == CW'(NB - 1)) begin
          bottom_nxt = quo_step[DB-1:0];
          state_nxt  = frau_pkg::S_DONE;
        end
      end
      frau_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_num_nxt   = top_r;
          out_den_nxt   = bottom_r;
          out_valid_nxt = 1'b1;
          state_nxt     = frau_pkg::S_IDLE;
        end
      end
      default: state_nxt = frau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frau_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      mul_cnt_r   <= 2'd0;
      div_cnt_r   <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n1_r      <= n1_nxt;
    d1_r      <= d1_nxt;
    n2_r      <= n2_nxt;
    d2_r      <= d2_nxt;
    prod_r    <= prod_nxt;
    top_r     <= top_nxt;
    bottom_r  <= bottom_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
  end

  assign in_ready            = (state_r == frau_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_sum_numerator   = out_num_r;
  assign out_sum_denominator = out_den_r;

  `FRAU_ASSERT_NOW(a_gcd_nonzero, clk, rst_n, state_r == frau_pkg::S_GCD, a_r != '0 && b_r != '0, "gcd operand reached zero")
  `FRAU_ASSERT_NOW(a_div_rem_below, clk, rst_n, dividing, rem_r < a_r, "divider remainder not below divisor")
  `FRAU_ASSERT_NOW(a_zero_den_mark, clk, rst_n, out_valid_r && out_den_r == '0, out_num_r == '0, "zero denominator with nonzero numerator")

endmodule

[dv/fraction_add_reduce_checker.sv]
// Checker for the fraction add-and-reduce unit: predicts each reduced sum and compares results
module fraction_add_reduce_checker #(
  parameter int VALUE_BITS = frau_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [VALUE_BITS-1:0]   in_first_numerator,
  input  logic [VALUE_BITS-1:0]   in_first_denominator,
  input  logic [VALUE_BITS-1:0]   in_second_numerator,
  input  logic [VALUE_BITS-1:0]   in_second_denominator,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [2*VALUE_BITS:0]   out_sum_numerator,
  input  logic [2*VALUE_BITS-1:0] out_sum_denominator,
  output int                      failures,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW = 2 * VALUE_BITS + 1;
  localparam int DW = 2 * VALUE_BITS;

  typedef struct packed {
    logic [2*VALUE_BITS:0]   num;
    logic [2*VALUE_BITS-1:0] den;
  } fraction_t;

  fraction_t expected_sums[$];

  function automatic fraction_t reduced_sum(
    input logic [VALUE_BITS-1:0] n1,
    input logic [VALUE_BITS-1:0] d1,
    input logic [VALUE_BITS-1:0] n2,
    input logic [VALUE_BITS-1:0] d2
  );
    logic [2*VALUE_BITS:0]   top;
    logic [2*VALUE_BITS-1:0] bottom;
    logic [2*VALUE_BITS:0]   a;
    logic [2*VALUE_BITS:0]   b;
    logic [2*VALUE_BITS:0]   r;
    fraction_t               f;
    // a zero denominator is marked as 0/0
    if (d1 == '0 || d2 == '0) begin
      f.num = '0;
      f.den = '0;
      return f;
    end
    top    = NW'(n1) * NW'(d2) + NW'(n2) * NW'(d1);
    bottom = DW'(d1) * DW'(d2);
    a = top;
    b = NW'(bottom);
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    // zero sum: gcd is the product, giving 0/1
    f.num = top / a;
    f.den = DW'(NW'(bottom) / a);
    return f;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    failures = failures + 1;
  endtask

  always @(posedge clk) begin
    fraction_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %0d/%0d",
                                  out_sum_numerator, out_sum_denominator));
        end else begin
          want = expected_sums.pop_front();
          if (out_sum_numerator !== want.num)
            flag_mismatch($sformatf("numerator %0d, expected %0d",
                                    out_sum_numerator, want.num));
          if (out_sum_denominator !== want.den)
            flag_mismatch($sformatf("denominator %0d, expected %0d",
                                    out_sum_denominator, want.den));
        end
      end
      if (in_valid && in_ready)
        expected_sums.insert(expected_sums.size(),
                             reduced_sum(in_first_numerator, in_first_denominator,
                                         in_second_numerator, in_second_denominator));
      pending = expected_sums.size();
    end
  end

endmodule

[dv/tb_fraction_add_reduce_unit.sv]
// Testbench top for the fraction add-and-reduce unit: stimulus, idling and verdict
module tb_fraction_add_reduce_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB           = frau_pkg::VALUE_BITS_DEF;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 250;

  logic            clk   = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [VB-1:0]   in_first_numerator    = '0;
  logic [VB-1:0]   in_first_denominator  = '0;
  logic [VB-1:0]   in_second_numerator   = '0;
  logic [VB-1:0]   in_second_denominator = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [2*VB:0]   out_sum_numerator;
  logic [2*VB-1:0] out_sum_denominator;
  int              failures;
  int              pending;
  int              cycles = 0;
  bit              in_calm = 1'b0;
  bit              out_calm = 1'b0;

  always #10 clk = ~clk;

  fraction_add_reduce_unit #(.VALUE_BITS(VB)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_first_numerator    (in_first_numerator),
    .in_first_denominator  (in_first_denominator),
    .in_second_numerator   (in_second_numerator),
    .in_second_denominator (in_second_denominator),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_sum_numerator     (out_sum_numerator),
    .out_sum_denominator   (out_sum_denominator)
  );

  fraction_add_reduce_checker #(.VALUE_BITS(VB)) checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_first_numerator    (in_first_numerator),
    .in_first_denominator  (in_first_denominator),
    .in_second_numerator   (in_second_numerator),
    .in_second_denominator (in_second_denominator),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_sum_numerator     (out_sum_numerator),
    .out_sum_denominator   (out_sum_denominator),
    .failures              (failures),
    .pending               (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_fractions(
    input logic [VB-1:0] n1,
    input logic [VB-1:0] d1,
    input logic [VB-1:0] n2,
    input logic [VB-1:0] d2
  );
    int gap;
    if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_first_numerator    <= n1;
    in_first_denominator  <= d1;
    in_second_numerator   <= n2;
    in_second_denominator <= d2;
    in_valid              <= 1'b1;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
  endtask

  // result side: stall per transfer, with calm stretches
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin
    logic [VB-1:0] n1;
    logic [VB-1:0] d1;
    logic [VB-1:0] n2;
    logic [VB-1:0] d2;
    int unsigned   f;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero sums
    send_fractions(16'd0, 16'd1, 16'd0, 16'd1);
    send_fractions(16'd0, 16'hFFFF, 16'd0, 16'hFFFE);
    // zero denominators
    send_fractions(16'd1, 16'd0, 16'd1, 16'd1);
    send_fractions(16'd1, 16'd1, 16'd1, 16'd0);
    send_fractions(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    send_fractions(16'd0, 16'd0, 16'd0, 16'd5);
    // extremes
    send_fractions(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fractions(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
    send_fractions(16'hFFFF, 16'hFFFE, 16'hFFFD, 16'hFFF1);
    send_fractions(16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF);
    send_fractions(16'd1, 16'hFFFF, 16'd1, 16'hFFFE);
    send_fractions(16'd0, 16'd1, 16'hFFFF, 16'hFFFF);
    send_fractions(16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
    // simple reductions and wide powers of two
    send_fractions(16'd1, 16'd2, 16'd1, 16'd2);
    send_fractions(16'd1, 16'd3, 16'd1, 16'd6);
    send_fractions(16'd16384, 16'd32768, 16'd16384, 16'd32768);
    send_fractions(16'd1, 16'd32768, 16'd1, 16'd32768);
    send_fractions(16'd32768, 16'd1, 16'd32768, 16'd1);
    send_fractions(16'd5, 16'd7, 16'd3, 16'd11);
    send_fractions(16'd255, 16'd65280, 16'd257, 16'd65535);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          n1 = 16'($urandom); d1 = 16'($urandom);
          n2 = 16'($urandom); d2 = 16'($urandom);
        end
        5, 6, 7, 8: begin
          n1 = 16'($urandom_range(0, 20)); d1 = 16'($urandom_range(1, 20));
          n2 = 16'($urandom_range(0, 20)); d2 = 16'($urandom_range(1, 20));
        end
        9, 10, 11: begin
          f  = $urandom_range(1, 255);
          n1 = 16'(f * $urandom_range(0, 257)); d1 = 16'(f * $urandom_range(1, 257));
          n2 = 16'(f * $urandom_range(0, 257)); d2 = 16'(f * $urandom_range(1, 257));
        end
        12, 13: begin
          n1 = 16'($urandom); n2 = 16'($urandom);
          d1 = 16'd1 << $urandom_range(0, 15);
          d2 = 16'd1 << $urandom_range(0, 15);
        end
        14: begin
          n1 = 16'd0; n2 = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
          d1 = 16'($urandom_range(1, 65535)); d2 = 16'($urandom_range(1, 65535));
        end
        15, 16, 17: begin
          n1 = 16'(16'hFFFF - $urandom_range(0, 15));
          d1 = 16'(16'hFFFF - $urandom_range(0, 15));
          n2 = 16'(16'hFFFF - $urandom_range(0, 15));
          d2 = 16'(16'hFFFF - $urandom_range(0, 15));
        end
        default: begin
          n1 = 16'($urandom); n2 = 16'($urandom);
          d1 = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
          d2 = (d1 != 16'd0 && $urandom_range(0, 1)) ? 16'd0 : 16'($urandom);
          if (d1 != 16'd0 && d2 != 16'd0) d2 = 16'd0;
        end
      endcase
      send_fractions(n1, d1, n2, d2);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
